>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CKL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CKL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ckl_pkg.sv
package ckl_pkg;

    localparam int NUM_KEYWORDS         = 12;
    localparam int KW_IDX_BITS          = $clog2(NUM_KEYWORDS);
    localparam int MAX_WORD_LEN_DEFAULT = 99;
    localparam int COUNT_BITS_DEFAULT   = 32;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // keywords left-aligned, first character in the top byte
    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        {"auto", 32'd0}, {"break", 24'd0}, {"case", 32'd0}, {"char", 32'd0},
        {"const", 24'd0}, "continue", {"default", 8'd0}, {"define", 16'd0},
        "unsigned", {"void", 32'd0}, "volatile", {"while", 24'd0}
    };

    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd8, 4'd4, 4'd8, 4'd5
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } text_t;

    typedef struct packed {
        logic [3:0]  keyword_index;
        logic [31:0] keyword_count;
        logic        is_report;
        logic        last;
    } result_t;

    // command from front to back
    typedef struct packed {
        logic                   is_eoi;
        logic                   has_hit;
        logic [KW_IDX_BITS-1:0] idx;
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_PREPROC = 3'd3
    } mode_t;

    typedef enum logic {
        BK_RUN    = 1'b0,
        BK_REPORT = 1'b1
    } back_state_t;

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        logic [2:0] sh;
        sh = 3'd7 - pos;
        return KW_TEXT[k][{sh, 3'b000} +: 8];
    endfunction

endpackage

>>> design/ckl_queue.sv
module ckl_queue
    import ckl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   fill_reg;

    assign full  = (fill_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/ckl_front.sv
module ckl_front
    import ckl_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  text_valid,
    output logic  text_ready,
    input  text_t text,
    output logic  push,
    output cmd_t  push_cmd,
    input  logic  full
);

    localparam int WL = $clog2(MAX_WORD_LEN + 1);

    mode_t                   mode_reg, mode_next;
    logic [7:0]              prev_reg, prev_next;
    logic                    in_word_reg, in_word_next;
    logic [WL-1:0]           len_reg, len_next;
    logic [NUM_KEYWORDS-1:0] mask_reg, mask_next;

    logic                    accept;
    logic [7:0]              c;
    logic                    is_alpha, is_digit, is_starter, is_wordch;
    logic                    hit_found;
    logic [KW_IDX_BITS-1:0]  hit_idx;

    // drop keywords too short to reach pos or whose character at pos differs from ch
    function automatic logic [NUM_KEYWORDS-1:0] step_mask(
        input logic [NUM_KEYWORDS-1:0] m,
        input logic [WL-1:0]           pos,
        input logic [7:0]              ch
    );
        logic [NUM_KEYWORDS-1:0] r;
        r = m;
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            if (pos >= WL'(KW_LEN[k]) || kw_char(k, pos[2:0]) != ch)
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    assign text_ready = !full;
    assign accept     = text_valid && text_ready;
    assign c          = text.text_byte;
    assign is_alpha   = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign is_digit   = (c >= 8'h30 && c <= 8'h39);
    assign is_starter = is_alpha || (c == CH_UNDER);
    assign is_wordch  = is_starter || is_digit;

    // exact match of the pending word, lowest table position wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (in_word_reg && mask_reg[k] && len_reg == WL'(KW_LEN[k]))
            begin
                hit_found = 1'b1;
                hit_idx   = KW_IDX_BITS'(k);
            end
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        prev_next    = prev_reg;
        in_word_next = in_word_reg;
        len_next     = len_reg;
        mask_next    = mask_reg;
        push         = 1'b0;
        push_cmd     = '{is_eoi: 1'b0, has_hit: hit_found, idx: hit_idx};

        if (accept)
        begin
            if (text.end_of_input)
            begin
                push         = 1'b1;
                push_cmd     = '{is_eoi: 1'b1, has_hit: hit_found, idx: hit_idx};
                in_word_next = 1'b0;
                len_next     = '0;
                mask_next    = '0;
                mode_next    = MODE_NORMAL;
                prev_next    = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_COMMENT:
                    begin
                        if (prev_reg == CH_STAR && c == CH_SLASH)
                        begin
                            mode_next = MODE_NORMAL;
                            prev_next = '0;
                        end
                        else
                        begin
                            prev_next = c;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (prev_reg == CH_BSLASH)
                        begin
                            prev_next = '0;
                        end
                        else if (c == CH_QUOTE)
                        begin
                            mode_next = MODE_NORMAL;
                            prev_next = '0;
                        end
                        else
                        begin
                            prev_next = c;
                        end
                    end
                    MODE_PREPROC:
                    begin
                        if (c == CH_NEWLINE)
                        begin
                            mode_next = MODE_NORMAL;
                            prev_next = '0;
                        end
                    end
                    default:
                    begin
                        if (in_word_reg && is_wordch && len_reg < WL'(MAX_WORD_LEN))
                        begin
                            mask_next = step_mask(mask_reg, len_reg, c);
                            len_next  = len_reg + 1'b1;
                        end
                        else
                        begin
                            // word ends here, a hit goes to the back as last of this word
                            push         = hit_found;
                            in_word_next = 1'b0;
                            len_next     = '0;
                            mask_next    = '0;
                            if (is_starter)
                            begin
                                in_word_next = 1'b1;
                                mask_next    = step_mask('1, '0, c);
                                len_next     = WL'(1);
                            end
                        end

                        if (prev_reg == CH_SLASH && c == CH_STAR)
                        begin
                            mode_next = MODE_COMMENT;
                            prev_next = '0;
                        end
                        else if (c == CH_QUOTE && prev_reg != CH_BSLASH)
                        begin
                            mode_next = MODE_STRING;
                            prev_next = '0;
                        end
                        else if (c == CH_HASH)
                        begin
                            mode_next = MODE_PREPROC;
                            prev_next = '0;
                        end
                        else
                        begin
                            mode_next = MODE_NORMAL;
                            prev_next = c;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            prev_reg    <= '0;
            in_word_reg <= 1'b0;
            len_reg     <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            prev_reg    <= prev_next;
            in_word_reg <= in_word_next;
            len_reg     <= len_next;
            mask_reg    <= mask_next;
        end
    end

endmodule

>>> design/ckl_back.sv
module ckl_back
    import ckl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head,
    input  logic    empty,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int SHOW_BITS = (COUNT_BITS < 32) ? COUNT_BITS : 32;

    back_state_t            state_reg, state_next;
    logic [KW_IDX_BITS-1:0] rep_idx_reg, rep_idx_next;
    logic [COUNT_BITS-1:0]  count_reg [NUM_KEYWORDS];
    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;

    logic                   slot_free;
    logic [KW_IDX_BITS-1:0] rd_idx;
    logic [COUNT_BITS-1:0]  rd_count;
    logic [COUNT_BITS-1:0]  inc_count;
    logic                   inc_en;

    assign slot_free = !res_valid_reg || result_ready;
    assign rd_idx    = (state_reg == BK_REPORT) ? rep_idx_reg : head.idx;
    assign rd_count  = count_reg[rd_idx];
    assign inc_count = (rd_count == '1) ? rd_count : rd_count + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        rep_idx_next   = rep_idx_reg;
        pop            = 1'b0;
        inc_en         = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;

        case (state_reg)
            BK_RUN:
            begin
                if (slot_free && !empty)
                begin
                    pop = 1'b1;
                    if (head.has_hit)
                    begin
                        inc_en         = 1'b1;
                        res_valid_next = 1'b1;
                        res_next       = '{keyword_index: 4'(head.idx),
                                           keyword_count: 32'(inc_count[SHOW_BITS-1:0]),
                                           is_report: 1'b0,
                                           last: !head.is_eoi};
                    end
                    if (head.is_eoi)
                    begin
                        state_next   = BK_REPORT;
                        rep_idx_next = '0;
                    end
                end
            end
            BK_REPORT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{keyword_index: 4'(rep_idx_reg),
                                       keyword_count: 32'(rd_count[SHOW_BITS-1:0]),
                                       is_report: 1'b1,
                                       last: rep_idx_reg == KW_IDX_BITS'(NUM_KEYWORDS - 1)};
                    if (rep_idx_reg == KW_IDX_BITS'(NUM_KEYWORDS - 1))
                    begin
                        state_next = BK_RUN;
                    end
                    else
                    begin
                        rep_idx_next = rep_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            rep_idx_reg   <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_KEYWORDS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rep_idx_reg   <= rep_idx_next;
            res_valid_reg <= res_valid_next;
            if (inc_en)
            begin
                count_reg[rd_idx] <= inc_count;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> design/c_keyword_counting_lexer_core.sv
// C keyword counter. Takes one source byte per cycle on the text channel; comment bodies,
// string bodies and preprocessor lines are skipped, identifiers are matched against twelve
// keywords (auto .. while), and each hit leaves as a word on the result channel with the
// keyword's saturating count. An end-of-input word flushes the pending identifier and then
// gives one report word per keyword, the twelfth marked last. The byte filter and matcher
// take a byte every cycle; they hand hits and end-of-input to the counter side through a
// four-entry command queue, so the text side stalls only when that queue is full. The counter
// side sends one result per cycle while result_ready is high, reading one count register per
// cycle: an end-of-input word gives the flushed identifier's hit, if there is one, and then
// the twelve reports. Counts clear at reset and are kept across ends of input.
module c_keyword_counting_lexer_core
    import ckl_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEFAULT,
    parameter int COUNT_BITS   = COUNT_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    text_valid,
    output logic    text_ready,
    input  text_t   text,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t head;
    logic empty;

    ckl_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full)
    );

    ckl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    ckl_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> design/ckl_checker.sv
`include "assert_macros.svh"

module ckl_checker
    import ckl_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // a stalled result word holds
    `CKL_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result word changed while stalled")

    `CKL_ASSERT_NOW(a_index_range, clk, rst_n, result_valid, result.keyword_index <= 4'(NUM_KEYWORDS - 1), "keyword index out of table")

    // summary ends exactly at the last table entry
    `CKL_ASSERT_NOW(a_report_last, clk, rst_n, result_valid && result.is_report, result.last == (result.keyword_index == 4'(NUM_KEYWORDS - 1)), "report last flag misplaced")

endmodule

bind c_keyword_counting_lexer_core ckl_checker u_checker (.*);
